@@ hw/rtl/utf8_glyph_text_layout_assert.svh @@
// Assertion macros shared by the layout block.
`ifndef UTF8_GLYPH_TEXT_LAYOUT_ASSERT_SVH
`define UTF8_GLYPH_TEXT_LAYOUT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// prop must hold at every clock edge outside reset
`define UGTL_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// cond must never be true outside reset
`define UGTL_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define UGTL_ASSERT(label, clk, rst, prop, msg)
`define UGTL_ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

@@ hw/rtl/ugtl_pkg.sv @@
package ugtl_pkg;

  localparam int COORD_W = 16;
  localparam int CMP_W = COORD_W + 1;
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
  localparam int CFG_IDX_W = 3;

  localparam logic [15:0] CP_BIAS = 16'd19968;
  localparam logic [15:0] GLYPH_SKIP = 16'd95;
  localparam logic [15:0] ASCII_BASE = 16'd32;
  localparam logic [31:0] HEADER_BYTES = 32'd5;
  localparam logic [3:0] LEAD_TAG = 4'hE;

  typedef logic [COORD_W-1:0] coord_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X     = 3'd0,
    REG_ORIGIN_Y     = 3'd1,
    REG_BOX_WIDTH    = 3'd2,
    REG_BOX_HEIGHT   = 3'd3,
    REG_GLYPH_WIDTH  = 3'd4,
    REG_GLYPH_HEIGHT = 3'd5,
    REG_TEXT_COLOR   = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    EV_DRAW  = 2'd0,
    EV_END   = 2'd1,
    EV_FULL  = 2'd2
  } event_kind_t;

  typedef enum logic [1:0] {
    EK_NONE = 2'd0,
    EK_DRAW = 2'd1,
    EK_END  = 2'd2
  } entry_kind_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_CONT1 = 2'd1,
    PH_CONT2 = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       start_of_text;
  } in_item_t;

  typedef struct packed {
    event_kind_t event_kind;
    logic [15:0] draw_x;
    logic [15:0] draw_y;
    logic [15:0] glyph_index;
    logic [31:0] glyph_offset;
  } out_item_t;

  // queued work between decoder and placer
  typedef struct packed {
    logic        start;
    entry_kind_t kind;
    logic [15:0] index;
    logic [31:0] product;
  } entry_t;

  typedef struct packed {
    logic [11:0] origin_x;
    logic [11:0] origin_y;
    logic [12:0] x_limit;
    logic [12:0] y_limit;
    logic [7:0]  glyph_width;
    logic [7:0]  glyph_height;
    logic [15:0] glyph_area;
  } cfg_t;

  function automatic coord_t sat_add(coord_t a, logic [7:0] b);
    logic [COORD_W:0] sum;
    sum = {1'b0, a} + CMP_W'(b);
    return sum[COORD_W] ? '1 : sum[COORD_W-1:0];
  endfunction

endpackage

@@ hw/rtl/ugtl_front.sv @@
`include "utf8_glyph_text_layout_assert.svh"

module ugtl_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ugtl_pkg::in_item_t in_data,
  input  logic [15:0]       glyph_area,
  input  logic              full,
  output logic              push,
  output ugtl_pkg::entry_t  push_data
);

  ugtl_pkg::phase_t phase, phase_next;
  logic [9:0]       partial, partial_next;
  ugtl_pkg::phase_t ph_in;
  logic [9:0]       part_in;
  logic [15:0]      cp;
  logic [7:0]       b;
  logic             accept;

  assign in_ready = !full;
  assign accept = in_valid && in_ready;
  assign b = in_data.text_byte;
  assign cp = {part_in, b[5:0]};

  always_comb begin
    // start of text clears the decoder before the byte is looked at
    ph_in = in_data.start_of_text ? ugtl_pkg::PH_IDLE : phase;
    part_in = in_data.start_of_text ? 10'd0 : partial;
    phase_next = ugtl_pkg::PH_IDLE;
    partial_next = part_in;
    push_data.start = in_data.start_of_text;
    push_data.kind = ugtl_pkg::EK_NONE;
    push_data.index = 16'd0;
    unique case (ph_in)
      ugtl_pkg::PH_CONT1: begin
        partial_next = {part_in[3:0], b[5:0]};
        phase_next = ugtl_pkg::PH_CONT2;
      end
      ugtl_pkg::PH_CONT2: begin
        partial_next = 10'd0;
        push_data.kind = ugtl_pkg::EK_DRAW;
        push_data.index = cp - ugtl_pkg::CP_BIAS + ugtl_pkg::GLYPH_SKIP;
      end
      default: begin
        if (b == 8'd0) begin
          push_data.kind = ugtl_pkg::EK_END;
        end else if (!b[7]) begin
          push_data.kind = ugtl_pkg::EK_DRAW;
          push_data.index = {8'd0, b} - ugtl_pkg::ASCII_BASE;
        end else if (b[7:4] == ugtl_pkg::LEAD_TAG) begin
          partial_next = {6'd0, b[3:0]};
          phase_next = ugtl_pkg::PH_CONT1;
        end else begin
          push_data.kind = ugtl_pkg::EK_DRAW;
        end
      end
    endcase
    push_data.product = {16'd0, glyph_area} * {16'd0, push_data.index};
    push = accept && (in_data.start_of_text || push_data.kind != ugtl_pkg::EK_NONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= ugtl_pkg::PH_IDLE;
      partial <= 10'd0;
    end else if (accept) begin
      phase <= phase_next;
      partial <= partial_next;
    end
  end

  `UGTL_ASSERT(a_lead_then_cont, clk, rst, accept && phase_next == ugtl_pkg::PH_CONT1 |=> phase == ugtl_pkg::PH_CONT1, "lead byte did not open a sequence")
  `UGTL_ASSERT_NEVER(a_push_full, clk, rst, push && full, "push into a full queue")

endmodule

@@ hw/rtl/ugtl_queue.sv @@
`include "utf8_glyph_text_layout_assert.svh"

module ugtl_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ugtl_pkg::entry_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output ugtl_pkg::entry_t head
);

  ugtl_pkg::entry_t mem [ugtl_pkg::Q_DEPTH];
  logic [ugtl_pkg::Q_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [ugtl_pkg::Q_CNT_W-1:0] count;

  assign full = count == ugtl_pkg::Q_CNT_W'(ugtl_pkg::Q_DEPTH);
  assign head_valid = count != '0;
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `UGTL_ASSERT_NEVER(a_pop_empty, clk, rst, pop && !head_valid, "pop from an empty queue")

endmodule

@@ hw/rtl/ugtl_back.sv @@
`include "utf8_glyph_text_layout_assert.svh"

module ugtl_back (
  input  logic               clk,
  input  logic               rst,
  input  ugtl_pkg::cfg_t     cfg,
  input  logic               head_valid,
  input  ugtl_pkg::entry_t   head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output ugtl_pkg::out_item_t out_data
);

  ugtl_pkg::coord_t cursor_x, cursor_y, cursor_x_next, cursor_y_next;
  ugtl_pkg::coord_t cx, cy, cx_w, cy_w;
  logic             stopped, stopped_next, stop_in;
  logic             wrap, over;
  logic             emit;
  ugtl_pkg::out_item_t res;

  assign pop = head_valid && (!out_valid || out_ready);

  always_comb begin
    cx = head.start ? ugtl_pkg::COORD_W'(cfg.origin_x) : cursor_x;
    cy = head.start ? ugtl_pkg::COORD_W'(cfg.origin_y) : cursor_y;
    stop_in = head.start ? 1'b0 : stopped;
    wrap = {1'b0, cx} > ugtl_pkg::CMP_W'(cfg.x_limit);
    cx_w = wrap ? ugtl_pkg::COORD_W'(cfg.origin_x) : cx;
    cy_w = wrap ? ugtl_pkg::sat_add(cy, cfg.glyph_height) : cy;
    over = wrap && ({1'b0, cy_w} > ugtl_pkg::CMP_W'(cfg.y_limit));
    cursor_x_next = cx;
    cursor_y_next = cy;
    stopped_next = stop_in;
    emit = 1'b0;
    res = '0;
    if (!stop_in) begin
      unique case (head.kind)
        ugtl_pkg::EK_END: begin
          emit = 1'b1;
          stopped_next = 1'b1;
          res.event_kind = ugtl_pkg::EV_END;
        end
        ugtl_pkg::EK_DRAW: begin
          emit = 1'b1;
          cursor_x_next = cx_w;
          cursor_y_next = cy_w;
          if (over) begin
            stopped_next = 1'b1;
            res.event_kind = ugtl_pkg::EV_FULL;
          end else begin
            res.event_kind = ugtl_pkg::EV_DRAW;
            res.draw_x = 16'(cx_w);
            res.draw_y = 16'(cy_w);
            res.glyph_index = head.index;
            res.glyph_offset = head.product + ugtl_pkg::HEADER_BYTES;
            cursor_x_next = ugtl_pkg::sat_add(cx_w, cfg.glyph_width);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x <= '0;
      cursor_y <= '0;
      stopped <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        cursor_x <= cursor_x_next;
        cursor_y <= cursor_y_next;
        stopped <= stopped_next;
        out_valid <= emit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_data <= res;
    end
  end

  `UGTL_ASSERT(a_stop_quiet, clk, rst, pop && stopped && !head.start |=> !out_valid, "result while stopped")
  `UGTL_ASSERT(a_end_stops, clk, rst, pop && emit && res.event_kind != ugtl_pkg::EV_DRAW |=> stopped, "end or full did not stop")

endmodule

@@ hw/rtl/utf8_glyph_text_layout.sv @@
// A result from an accepted byte passes the queue, then the output register, to out_valid.
// Throughput: 1 item per cycle while neither side stalls; the placer moves the cursor per glyph.
// The decoder and the placer are parted by a 4-entry queue; each stalls on its own.
// Reset (rst, synchronous, active high): cursor, decoder and stop flag clear,
// the queue empties and the configuration registers return to their defaults.
module utf8_glyph_text_layout (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  ugtl_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output ugtl_pkg::out_item_t                out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ugtl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [15:0]                        cfg_data
);

  // Configuration. Wrap and stop limits and the glyph area are kept up to
  // date at write time so the item path sees only finished values.
  ugtl_pkg::cfg_t cfg;
  logic [11:0] box_width, box_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x <= 12'd0;
      cfg.origin_y <= 12'd0;
      box_width <= 12'd50;
      box_height <= 12'd50;
      cfg.x_limit <= 13'd50;
      cfg.y_limit <= 13'd50;
      cfg.glyph_width <= 8'd8;
      cfg.glyph_height <= 8'd16;
      cfg.glyph_area <= 16'd128;
    end else if (cfg_valid) begin
      unique case (ugtl_pkg::cfg_reg_t'(cfg_index))
        ugtl_pkg::REG_ORIGIN_X: begin
          cfg.origin_x <= cfg_data[11:0];
          cfg.x_limit <= {1'b0, cfg_data[11:0]} + {1'b0, box_width};
        end
        ugtl_pkg::REG_ORIGIN_Y: begin
          cfg.origin_y <= cfg_data[11:0];
          cfg.y_limit <= {1'b0, cfg_data[11:0]} + {1'b0, box_height};
        end
        ugtl_pkg::REG_BOX_WIDTH: begin
          box_width <= cfg_data[11:0];
          cfg.x_limit <= {1'b0, cfg.origin_x} + {1'b0, cfg_data[11:0]};
        end
        ugtl_pkg::REG_BOX_HEIGHT: begin
          box_height <= cfg_data[11:0];
          cfg.y_limit <= {1'b0, cfg.origin_y} + {1'b0, cfg_data[11:0]};
        end
        ugtl_pkg::REG_GLYPH_WIDTH: begin
          cfg.glyph_width <= cfg_data[7:0];
          cfg.glyph_area <= {8'd0, cfg_data[7:0]} * {8'd0, cfg.glyph_height};
        end
        ugtl_pkg::REG_GLYPH_HEIGHT: begin
          cfg.glyph_height <= cfg_data[7:0];
          cfg.glyph_area <= {8'd0, cfg.glyph_width} * {8'd0, cfg_data[7:0]};
        end
        // color only matters to the downstream drawer; nothing here uses it
        ugtl_pkg::REG_TEXT_COLOR: begin
        end
        default: begin
        end
      endcase
    end
  end

  // front: byte decode and offset product
  logic             push, full, pop, head_valid;
  ugtl_pkg::entry_t push_data, head;

  ugtl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .glyph_area (cfg.glyph_area),
    .full       (full),
    .push       (push),
    .push_data  (push_data)
  );

  // decoupling queue
  ugtl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // back: cursor, wrap/stop tests, output register
  ugtl_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
